// ===== design/grb_pkg.sv =====
// Shared types and constants for the grid restriction box-average block.
// Used by grb_pos, grb_accum and grid_restrict_box_average; no dependencies.
package grb_pkg;

  // Rank codes as written to the rank register.
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_1    = 2'd1;
  localparam logic [1:0] RANK_2    = 2'd2;
  localparam logic [1:0] RANK_3    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RANK = 2'd0;
  localparam logic [1:0] CFG_NX   = 2'd1;
  localparam logic [1:0] CFG_NY   = 2'd2;
  localparam logic [1:0] CFG_NZ   = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int RANK_W      = 2;

  // The z extent is fixed by the register width, not by a parameter.
  localparam int MAX_COARSE_Z = 256;
  localparam int FZ_W         = 9;   // fine z position
  localparam int FZ_EXT_W     = 10;  // fine z extent, up to 512
  localparam int COORD_W      = 8;   // coarse index as presented on the output

  // Per-sample decode handed from the position sequencer to the accumulator.
  typedef struct packed {
    logic [RANK_W-1:0] rank;  // normalized rank, 1..3
    logic              x_odd;
    logic              y_odd;
    logic              z_odd;
    logic              last;  // last sample of the region
  } grb_step_t;

endpackage

// ===== design/grb_pos.sv =====
// Position sequencer: fine x/y/z counters and the per-sample decode.
// Depends on grb_pkg.
module grb_pos #(
  parameter int MAX_COARSE_X = 256,
  parameter int MAX_COARSE_Y = 256,
  parameter int CXW = 8,
  parameter int CYW = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             start,
  input  logic [grb_pkg::RANK_W-1:0]       cfg_rank,
  input  logic [grb_pkg::CFG_DATA_W-1:0]   cfg_nx,
  input  logic [grb_pkg::CFG_DATA_W-1:0]   cfg_ny,
  input  logic [grb_pkg::CFG_DATA_W-1:0]   cfg_nz,
  output logic [CXW-1:0]                   cx,
  output logic [CYW-1:0]                   cy,
  output logic [grb_pkg::COORD_W-1:0]      cz,
  output grb_pkg::grb_step_t               step
);
  import grb_pkg::*;

  localparam int XW  = $clog2(2 * MAX_COARSE_X);
  localparam int YW  = $clog2(2 * MAX_COARSE_Y);
  localparam int XFW = XW + 1;
  localparam int YFW = YW + 1;

  logic [XW-1:0]       x_pos, x_pos_next, cur_x;
  logic [YW-1:0]       y_pos, y_pos_next, cur_y;
  logic [FZ_W-1:0]     z_pos, z_pos_next, cur_z;
  logic [XFW-1:0]      fx, x_inc;
  logic [YFW-1:0]      fy, y_inc;
  logic [FZ_EXT_W-1:0] fz, z_inc;
  logic [RANK_W-1:0]   rk;

  // Effective rank and fine extents after clamping the size registers.
  always_comb begin
    rk = (cfg_rank == RANK_NONE) ? RANK_1 : cfg_rank;

    if (cfg_nx == '0) begin
      fx = XFW'(2);
    end else if (int'(cfg_nx) > MAX_COARSE_X) begin
      fx = XFW'(2 * MAX_COARSE_X);
    end else begin
      fx = XFW'({cfg_nx, 1'b0});
    end

    if (rk == RANK_1) begin
      fy = YFW'(1);
    end else if (cfg_ny == '0) begin
      fy = YFW'(2);
    end else if (int'(cfg_ny) > MAX_COARSE_Y) begin
      fy = YFW'(2 * MAX_COARSE_Y);
    end else begin
      fy = YFW'({cfg_ny, 1'b0});
    end

    if (rk != RANK_3) begin
      fz = FZ_EXT_W'(1);
    end else if (cfg_nz == '0) begin
      fz = FZ_EXT_W'(2);
    end else if (int'(cfg_nz) > MAX_COARSE_Z) begin
      fz = FZ_EXT_W'(2 * MAX_COARSE_Z);
    end else begin
      fz = FZ_EXT_W'({cfg_nz, 1'b0});
    end
  end

  // Current position: a start word or an out-of-range counter reads as zero.
  always_comb begin
    cur_x = (start || (XFW'(x_pos) >= fx)) ? '0 : x_pos;
    cur_y = (start || (YFW'(y_pos) >= fy)) ? '0 : y_pos;
    cur_z = (start || (FZ_EXT_W'(z_pos) >= fz)) ? '0 : z_pos;
  end

  // Raster advance, x fastest.
  always_comb begin
    x_inc = XFW'(cur_x) + XFW'(1);
    y_inc = YFW'(cur_y) + YFW'(1);
    z_inc = FZ_EXT_W'(cur_z) + FZ_EXT_W'(1);
    x_pos_next = XW'(x_inc);
    y_pos_next = cur_y;
    z_pos_next = cur_z;
    if (x_inc >= fx) begin
      x_pos_next = '0;
      y_pos_next = YW'(y_inc);
      if (y_inc >= fy) begin
        y_pos_next = '0;
        z_pos_next = FZ_W'(z_inc);
        if (z_inc >= fz) begin
          z_pos_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
      z_pos <= '0;
    end else if (accept) begin
      x_pos <= x_pos_next;
      y_pos <= y_pos_next;
      z_pos <= z_pos_next;
    end
  end

  // Decode handed to the accumulator.
  always_comb begin
    cx         = CXW'(cur_x >> 1);
    cy         = CYW'(cur_y >> 1);
    cz         = COORD_W'(cur_z >> 1);
    step.rank  = rk;
    step.x_odd = cur_x[0];
    step.y_odd = cur_y[0];
    step.z_odd = cur_z[0];
    step.last  = (XFW'(cur_x) == fx - XFW'(1)) && (YFW'(cur_y) == fy - YFW'(1)) &&
                 (FZ_EXT_W'(cur_z) == fz - FZ_EXT_W'(1));
  end

endmodule

// ===== design/grb_accum.sv =====
// Accumulator: pair register, row and plane sum memories, sum pipeline and
// output register. Depends on grb_pkg.
module grb_accum #(
  parameter int MAX_COARSE_X = 256,
  parameter int MAX_COARSE_Y = 256,
  parameter int SAMPLE_BITS  = 32,
  parameter int CXW = 8,
  parameter int CYW = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic [CXW-1:0]                     cx,
  input  logic [CYW-1:0]                     cy,
  input  logic [grb_pkg::COORD_W-1:0]        cz,
  input  grb_pkg::grb_step_t                 step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_value,
  output logic [grb_pkg::COORD_W-1:0]        out_x,
  output logic [grb_pkg::COORD_W-1:0]        out_y,
  output logic [grb_pkg::COORD_W-1:0]        out_z,
  output logic                               out_done
);
  import grb_pkg::*;

  localparam int SW1 = SAMPLE_BITS + 1;  // pair sum
  localparam int SW2 = SAMPLE_BITS + 2;  // quad sum, row and plane entries
  localparam int SW3 = SAMPLE_BITS + 3;  // cube sum
  localparam int PLANE_DEPTH = MAX_COARSE_X * MAX_COARSE_Y;
  localparam int PW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;

  // Sum memories.
  logic signed [SW2-1:0] row_mem   [MAX_COARSE_X];
  logic signed [SW2-1:0] plane_mem [PLANE_DEPTH];

  logic signed [SW1-1:0] pair_sum, pair_val;
  logic                  emit_a, use_rows, row_we, row_re, plane_re, plane_we_a;
  logic [PW-1:0]         plane_idx;

  // Stage B: memory read data lands here.
  logic                  valid_b, emit_b, use_row_b, use_plane_b, plane_we_b, done_b;
  logic [RANK_W-1:0]     shift_b;
  logic signed [SW1-1:0] pair_b;
  logic signed [SW2-1:0] row_rd, plane_rd, quad_b;
  logic [PW-1:0]         idx_b;
  logic [COORD_W-1:0]    x_b, y_b, z_b;

  // Stage C: final add and shift.
  logic                  valid_c, emit_c, use_plane_c, done_c;
  logic [RANK_W-1:0]     shift_c;
  logic signed [SW2-1:0] plane_c;
  logic signed [SW3-1:0] sum_c, total_c, mean_c;
  logic [COORD_W-1:0]    x_c, y_c, z_c;

  logic                  ready_c, move_b, out_load;

  // Flow control: a stage moves when the one ahead is free or moving.
  assign ready_c  = !valid_c || !emit_c || !out_valid || out_ready;
  assign move_b   = valid_b && ready_c;
  assign in_ready = !valid_b || ready_c;
  assign out_load = valid_c && emit_c && (!out_valid || out_ready);

  // Sample decode: what this word does to the pair, row and plane sums.
  always_comb begin
    pair_val   = step.x_odd ? (pair_sum + SW1'(sample)) : SW1'(sample);
    use_rows   = step.x_odd && (step.rank != RANK_1);
    row_we     = use_rows && !step.y_odd;
    row_re     = use_rows && step.y_odd;
    plane_re   = row_re && (step.rank == RANK_3) && step.z_odd;
    plane_we_a = row_re && (step.rank == RANK_3) && !step.z_odd;
    emit_a     = step.x_odd && ((step.rank == RANK_1) ||
                 (step.y_odd && ((step.rank == RANK_2) || step.z_odd)));
    plane_idx  = PW'(cy) * PW'(MAX_COARSE_X) + PW'(cx);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair_sum <= pair_val;
    end
  end

  // Row store: written and read at the accept edge.
  always_ff @(posedge clk) begin
    if (accept && row_we) begin
      row_mem[cx] <= SW2'(pair_val);
    end
    if (accept && row_re) begin
      row_rd <= row_mem[cx];
    end
  end

  // Plane store: read at the accept edge, written when the quad leaves stage B.
  always_ff @(posedge clk) begin
    if (accept && plane_re) begin
      plane_rd <= plane_mem[plane_idx];
    end
    if (move_b && plane_we_b) begin
      plane_mem[idx_b] <= quad_b;
    end
  end

  // Stage B registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (in_ready) begin
      valid_b <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit_b      <= emit_a;
      use_row_b   <= row_re;
      use_plane_b <= plane_re;
      plane_we_b  <= plane_we_a;
      shift_b     <= step.rank;
      pair_b      <= pair_val;
      idx_b       <= plane_idx;
      done_b      <= step.last;
      x_b         <= COORD_W'(cx);
      y_b         <= COORD_W'(cy);
      z_b         <= cz;
    end
  end

  assign quad_b = row_rd + SW2'(pair_b);

  // Stage C registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else if (ready_c) begin
      valid_c <= move_b;
    end
  end

  always_ff @(posedge clk) begin
    if (move_b) begin
      emit_c      <= emit_b;
      use_plane_c <= use_plane_b;
      shift_c     <= shift_b;
      plane_c     <= plane_rd;
      sum_c       <= use_row_b ? SW3'(quad_b) : SW3'(pair_b);
      done_c      <= done_b;
      x_c         <= x_b;
      y_c         <= y_b;
      z_c         <= z_b;
    end
  end

  // Block total and floor mean by arithmetic shift.
  always_comb begin
    total_c = use_plane_c ? (SW3'(plane_c) + sum_c) : sum_c;
    mean_c  = total_c >>> shift_c;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= SAMPLE_BITS'(mean_c);
      out_x     <= x_c;
      out_y     <= y_c;
      out_z     <= z_c;
      out_done  <= done_c;
    end
  end

  // The last sample of a region always closes an x pair.
  a_last_closes_pair: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!step.last || step.x_odd))
    else $error("region end on an even x position");

  // Input stalls only when every stage ahead is full and the output waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (valid_b && valid_c && emit_c && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  // A held stage B keeps its word.
  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    (valid_b && !ready_c) |=> valid_b)
    else $error("stage B word lost while stalled");

  // A pending result reaches an empty output register.
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    (valid_c && emit_c && !out_valid) |=> out_valid)
    else $error("result not loaded into output register");

  // A taken result with nothing behind it empties the output.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(valid_c && emit_c)) |=> !out_valid)
    else $error("output result repeated");

endmodule

// ===== design/grid_restrict_box_average.sv =====
// Top level of the grid box-average restriction block; configuration registers
// and stream ports. Depends on grb_pkg, grb_pos and grb_accum.
//
// Fine samples arrive in raster order (x fastest, then y, then z) and one word
// is taken every clock cycle while the output side keeps up; a block mean passes
// stage B, stage C and the output register after the word closing its 2, 2x2
// or 2x2x2 block. Each sample costs at most one read or write of the row store
// and at most one read and one write of the plane store, synchronous memories
// of MAX_COARSE_X and MAX_COARSE_X*MAX_COARSE_Y entries; these set the rate of
// one word per cycle. Neither store is cleared after reset: entries are always
// written in a region before they are read. Write configuration only while the
// block is idle; a start_volume word (s_tuser) restarts the region, and after
// the last sample the counters wrap so the next region may follow directly.
module grid_restrict_box_average #(
  parameter int MAX_COARSE_X = 256,
  parameter int MAX_COARSE_Y = 256,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [grb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [grb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Fine sample stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // fine_sample
  input  logic                              s_tuser,   // start_volume
  // Coarse result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // coarse_value, coarse_x, coarse_y, coarse_z
  output logic [((SAMPLE_BITS+24+7)/8)*8-1:0] m_tdata,
  output logic                              m_tlast    // volume_done
);
  import grb_pkg::*;

  localparam int CXW = (MAX_COARSE_X > 1) ? $clog2(MAX_COARSE_X) : 1;
  localparam int CYW = (MAX_COARSE_Y > 1) ? $clog2(MAX_COARSE_Y) : 1;
  localparam int OUT_W = ((SAMPLE_BITS + 24 + 7) / 8) * 8;

  logic [RANK_W-1:0]     cfg_rank;
  logic [CFG_DATA_W-1:0] cfg_nx, cfg_ny, cfg_nz;
  logic                  accept;
  logic [CXW-1:0]        cx;
  logic [CYW-1:0]        cy;
  logic [COORD_W-1:0]    cz;
  grb_step_t             step;

  logic signed [SAMPLE_BITS-1:0] out_value;
  logic [COORD_W-1:0]            out_x, out_y, out_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rank <= RANK_1;
      cfg_nx   <= CFG_DATA_W'(1);
      cfg_ny   <= CFG_DATA_W'(1);
      cfg_nz   <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANK: cfg_rank <= cfg_wdata[RANK_W-1:0];
        CFG_NX:   cfg_nx   <= cfg_wdata;
        CFG_NY:   cfg_ny   <= cfg_wdata;
        CFG_NZ:   cfg_nz   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  grb_pos #(
    .MAX_COARSE_X(MAX_COARSE_X),
    .MAX_COARSE_Y(MAX_COARSE_Y),
    .CXW(CXW),
    .CYW(CYW)
  ) u_pos (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .start(s_tuser),
    .cfg_rank(cfg_rank),
    .cfg_nx(cfg_nx),
    .cfg_ny(cfg_ny),
    .cfg_nz(cfg_nz),
    .cx(cx),
    .cy(cy),
    .cz(cz),
    .step(step)
  );

  grb_accum #(
    .MAX_COARSE_X(MAX_COARSE_X),
    .MAX_COARSE_Y(MAX_COARSE_Y),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CXW(CXW),
    .CYW(CYW)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .in_ready(s_tready),
    .sample($signed(s_tdata[SAMPLE_BITS-1:0])),
    .cx(cx),
    .cy(cy),
    .cz(cz),
    .step(step),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_value(out_value),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_done(m_tlast)
  );

  // Result word packing, first field in the lowest bits.
  assign m_tdata = OUT_W'({out_z, out_y, out_x, out_value});

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for grid_restrict_box_average: raster streams of fine
// samples in 1D, 2D and 3D, each coarse mean compared with an in-bench model.
// Depends on grb_pkg and the grid_restrict_box_average RTL only.
`timescale 1ns / 1ps

module tb_top;
  import grb_pkg::*;

  localparam int CELL_LIMIT   = 256;   // coarse cells per axis at the default sizes
  localparam int DRAIN_CYCLES = 16;    // extra wait for the pipeline to empty
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
  localparam int RANDOM_WORDS = 1900;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic        done;
  } coarse_cell_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_index;
    logic [8:0]  reg_value;
    logic [31:0] sample;
    logic        start;
    logic        known;       // mean typed in below, not taken from the model
    logic [31:0] want_value;
    logic        want_done;
  } script_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HOLD} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_RANK;
  logic [8:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // fine_sample
  logic        s_tuser = 1'b0;  // start_volume
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // coarse_value, coarse_x, coarse_y, coarse_z
  logic        m_tlast;         // volume_done

  // Model of the block: registers, fine position and partial sums.
  logic [1:0]         rank_reg;
  logic [8:0]         nx_reg, ny_reg, nz_reg;
  int unsigned        fine_x, fine_y, fine_z;
  logic signed [32:0] pair_sum;
  logic signed [33:0] row_sums [CELL_LIMIT];
  logic signed [33:0] plane_sums [CELL_LIMIT * CELL_LIMIT];

  coarse_cell_t pending_means[$];
  script_row_t  script[$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  burst_left = 0;
  rx_mode_e     rx_mode = RX_OPEN;
  int unsigned  rx_left = 0;
  int unsigned  hold_left = 0;
  logic         hold_level = 1'b1;

  grid_restrict_box_average #(
    .MAX_COARSE_X(CELL_LIMIT),
    .MAX_COARSE_Y(CELL_LIMIT),
    .SAMPLE_BITS (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A size of zero counts as one cell and anything past the store depth as full depth.
  function automatic int unsigned clamp_cells(logic [8:0] n);
    if (n == 0) return 1;
    if (n > CELL_LIMIT) return CELL_LIMIT;
    return 32'(n);
  endfunction

  // Effective rank and fine extents for the current register values.
  function automatic void region_shape(output logic [1:0] rk,
                                       output int unsigned fx, fy, fz);
    rk = (rank_reg == RANK_NONE) ? RANK_1 : rank_reg;
    fx = 2 * clamp_cells(nx_reg);
    fy = (rk != RANK_1) ? 2 * clamp_cells(ny_reg) : 1;
    fz = (rk == RANK_3) ? 2 * clamp_cells(nz_reg) : 1;
  endfunction

  // Advance the model by one fine sample; flags a mean when a block closes.
  task automatic average_step(input logic [31:0] sample, input logic start,
                              output bit emit, output coarse_cell_t coarse);
    logic [1:0]         rk;
    int unsigned        fx, fy, fz, cx, cy, cz, shift_by;
    logic signed [31:0] s;
    logic signed [33:0] quad;
    logic signed [34:0] total;
    logic signed [34:0] mean;
    region_shape(rk, fx, fy, fz);
    s = sample;
    emit = 1'b0;
    shift_by = 1;
    total = '0;
    coarse = '0;
    if (start) begin
      fine_x = 0;
      fine_y = 0;
      fine_z = 0;
    end
    // Positions left outside a shrunken region start over.
    if (fine_x >= fx) fine_x = 0;
    if (fine_y >= fy) fine_y = 0;
    if (fine_z >= fz) fine_z = 0;
    cx = fine_x >> 1;
    cy = fine_y >> 1;
    cz = fine_z >> 1;

    if (fine_x % 2 == 0) begin
      pair_sum = 33'(s);
    end else begin
      pair_sum = pair_sum + 33'(s);
      if (rk == RANK_1) begin
        total = 35'(pair_sum);
        emit = 1'b1;
      end else if (fine_y % 2 == 0) begin
        row_sums[cx] = 34'(pair_sum);
      end else begin
        quad = row_sums[cx] + 34'(pair_sum);
        if (rk == RANK_2) begin
          total = 35'(quad);
          shift_by = 2;
          emit = 1'b1;
        end else if (fine_z % 2 == 0) begin
          plane_sums[cy * CELL_LIMIT + cx] = quad;
        end else begin
          total = 35'(plane_sums[cy * CELL_LIMIT + cx]) + 35'(quad);
          shift_by = 3;
          emit = 1'b1;
        end
      end
    end

    // Arithmetic shift of the exact sum rounds toward negative infinity.
    if (emit) begin
      mean = total >>> shift_by;
      coarse.value = mean[31:0];
      coarse.x = cx[7:0];
      coarse.y = cy[7:0];
      coarse.z = cz[7:0];
      coarse.done = (fine_x == fx - 1) && (fine_y == fy - 1) && (fine_z == fz - 1);
    end

    fine_x++;
    if (fine_x >= fx) begin
      fine_x = 0;
      fine_y++;
      if (fine_y >= fy) begin
        fine_y = 0;
        fine_z++;
        if (fine_z >= fz) fine_z = 0;
      end
    end
  endtask

  // Present one word and hold it until the block takes it.
  task automatic accept_word(input logic [31:0] sample, input logic start,
                             input logic known, input coarse_cell_t literal);
    bit           emit;
    coarse_cell_t coarse;
    s_tvalid <= 1'b1;
    s_tdata <= sample;
    s_tuser <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    average_step(sample, start, emit, coarse);
    if (known) pending_means.push_back(literal);
    else if (emit) pending_means.push_back(coarse);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender bursts: zero gap while a burst lasts, then a short random pause.
  function automatic int unsigned sender_gap();
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 60);
    return $urandom_range(1, 12);
  endfunction

  // Stop sending, let every mean come out, then give the pipeline time to empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the enable stays high across back-to-back writes.
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val,
                           input bit last_one);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_RANK: rank_reg = val[1:0];
      CFG_NX:   nx_reg = val;
      CFG_NY:   ny_reg = val;
      CFG_NZ:   nz_reg = val;
      default: ;
    endcase
    if (last_one) cfg_we <= 1'b0;
  endtask

  function automatic logic [8:0] pick_cells(bit wide);
    if (!wide) return 9'($urandom_range(0, 4));
    case ($urandom_range(0, 2))
      0:       return 9'd256;
      1:       return 9'd511;
      default: return 9'($urandom_range(257, 510));
    endcase
  endfunction

  function automatic script_row_t cfg_row(logic [1:0] idx, logic [8:0] val);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  function automatic script_row_t word_row(logic [31:0] sample, logic start);
    script_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.sample = sample;
    r.start = start;
    return r;
  endfunction

  // A word that closes the only block of a one-cell region, at coarse index 0.
  function automatic script_row_t known_row(logic [31:0] sample, logic [31:0] value,
                                            logic done);
    script_row_t r;
    r = word_row(sample, 1'b0);
    r.known = 1'b1;
    r.want_value = value;
    r.want_done = done;
    return r;
  endfunction

  // Result side: check each word taken, then pick the next ready level.
  always @(posedge clk) begin : rx_side
    coarse_cell_t want;
    logic         ready_next;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected result word %h, last %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $error("coarse_value: expected %h, actual %h", want.value, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[39:32] !== want.x) begin
          $error("coarse_x: expected %0d, actual %0d", want.x, m_tdata[39:32]);
          mismatches++;
        end
        if (m_tdata[47:40] !== want.y) begin
          $error("coarse_y: expected %0d, actual %0d", want.y, m_tdata[47:40]);
          mismatches++;
        end
        if (m_tdata[55:48] !== want.z) begin
          $error("coarse_z: expected %0d, actual %0d", want.z, m_tdata[55:48]);
          mismatches++;
        end
        if (m_tlast !== want.done) begin
          $error("volume_done: expected %b, actual %b", want.done, m_tlast);
          mismatches++;
        end
      end
    end

    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:     ready_next = 1'b1;
      RX_RANDOM:   ready_next = ($urandom_range(0, 3) != 0);
      RX_PERIODIC: ready_next = (rx_left % 7) < 5;
      default: begin
        if (hold_left == 0) begin
          hold_level = 1'($urandom_range(0, 1));
          hold_left = $urandom_range(1, 24);
        end else begin
          hold_left--;
        end
        ready_next = hold_level;
      end
    endcase
    m_tready <= ready_next;
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    coarse_cell_t lit;
    logic [1:0]   rk, rank_pick, wide_reg;
    bit           has_wide;
    logic         start;
    logic [31:0]  sample;
    int unsigned  fx, fy, fz, region, phase_len, gap, words_sent;

    rank_reg = RANK_1;
    nx_reg = 9'd1;
    ny_reg = 9'd1;
    nz_reg = 9'd1;
    fine_x = 0;
    fine_y = 0;
    fine_z = 0;
    pair_sum = '0;
    words_sent = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    script = '{
      // Reset settings: rank 1, one coarse cell, regions follow without start_volume.
      word_row(32'h7FFF_FFFF, 1'b1),
      known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
      word_row(32'h8000_0000, 1'b0),
      known_row(32'h8000_0000, 32'h8000_0000, 1'b1),
      word_row(32'h0000_0001, 1'b0),
      known_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1),   // -1/2 floors to -1
      // Rank zero and size zero both act as one.
      cfg_row(CFG_RANK, {7'd0, RANK_NONE}),
      cfg_row(CFG_NX, 9'd0),
      word_row(32'd5, 1'b1),
      known_row(32'd6, 32'd5, 1'b1),
      // Row shrinks in mid-region: the x position past the new end restarts.
      cfg_row(CFG_NX, 9'd3),
      word_row(32'h0001_0000, 1'b1),
      word_row(32'hFFFF_0000, 1'b0),
      word_row(32'h1234_5678, 1'b0),
      cfg_row(CFG_NX, 9'd1),
      word_row(32'h8765_4321, 1'b0),
      word_row(32'h0000_0003, 1'b0),
      // One 2x2 block of the most negative sample.
      cfg_row(CFG_RANK, {7'd0, RANK_2}),
      cfg_row(CFG_NY, 9'd1),
      word_row(32'h8000_0000, 1'b1),
      word_row(32'h8000_0000, 1'b0),
      word_row(32'h8000_0000, 1'b0),
      known_row(32'h8000_0000, 32'h8000_0000, 1'b1),
      // One 2x2x2 block of the most positive sample.
      cfg_row(CFG_RANK, {7'd0, RANK_3}),
      cfg_row(CFG_NZ, 9'd1),
      word_row(32'h7FFF_FFFF, 1'b1),
      word_row(32'h7FFF_FFFF, 1'b0),
      word_row(32'h7FFF_FFFF, 1'b0),
      word_row(32'h7FFF_FFFF, 1'b0),
      word_row(32'h7FFF_FFFF, 1'b0),
      word_row(32'h7FFF_FFFF, 1'b0),
      word_row(32'h7FFF_FFFF, 1'b0),
      known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1)
    };

    // Directed rows; registers change only once the block has gone quiet.
    for (int i = 0; i < script.size(); i++) begin
      if (script[i].kind == ROW_CFG) begin
        if (i == 0 || script[i-1].kind != ROW_CFG) settle();
        write_reg(script[i].reg_index, script[i].reg_value,
                  i + 1 >= script.size() || script[i+1].kind != ROW_CFG);
      end else begin
        lit = '0;
        lit.value = script[i].want_value;
        lit.done = script[i].want_done;
        accept_word(script[i].sample, script[i].start, script[i].known, lit);
        if (i + 1 < script.size() && script[i+1].kind == ROW_WORD) begin
          gap = sender_gap();
          if (gap != 0) idle_sender(gap);
        end
      end
    end

    // Random phases: new settings each time, mostly small, now and then one axis at
    // its largest; each phase streams whole regions, at times with up to five words more, or a long partial one.
    lit = '0;
    while (words_sent < RANDOM_WORDS) begin
      settle();
      rank_pick = 2'($urandom_range(0, 3));
      has_wide = ($urandom_range(0, 7) == 0);
      wide_reg = 2'($urandom_range(1, 3));
      write_reg(CFG_RANK, {7'd0, rank_pick}, 1'b0);
      write_reg(CFG_NX, pick_cells(has_wide && wide_reg == CFG_NX), 1'b0);
      write_reg(CFG_NY, pick_cells(has_wide && wide_reg == CFG_NY), 1'b0);
      write_reg(CFG_NZ, pick_cells(has_wide && wide_reg == CFG_NZ), 1'b1);

      region_shape(rk, fx, fy, fz);
      region = fx * fy * fz;
      if (region > 600) phase_len = $urandom_range(200, 600);
      else phase_len = region * ((region > 200) ? 1 : $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) phase_len += $urandom_range(1, 5);
      // The last phase stops at the planned word count.
      if (phase_len > RANDOM_WORDS - words_sent) phase_len = RANDOM_WORDS - words_sent;

      for (int k = 0; k < phase_len; k++) begin
        // With the stores in use, a region left half done must be restarted so
        // that no sum is read before this region has written it.
        if (k == 0)
          start = (rk != RANK_1 && (fine_x | fine_y | fine_z) != 0) ? 1'b1
                                                                   : 1'($urandom_range(0, 1));
        else
          start = ($urandom_range(0, 63) == 0);
        case ($urandom_range(0, 7))
          0:       sample = 32'h7FFF_FFFF;
          1:       sample = 32'h8000_0000;
          2, 3:    sample = 32'($urandom_range(0, 8)) - 32'd4;
          default: sample = $urandom;
        endcase
        accept_word(sample, start, 1'b0, lit);
        words_sent++;
        if (k + 1 < phase_len) begin
          gap = sender_gap();
          if (gap != 0) idle_sender(gap);
        end
      end
    end

    settle();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/grb_pkg.sv
design/grb_pos.sv
design/grb_accum.sv
design/grid_restrict_box_average.sv
dv/tb_top.sv
